// File: design/picds_pkg.sv
// shared widths, codes and transfer types of the piecewise inverse-cdf sampler
// no dependencies; imported by every module of the block

package picds_pkg;

   localparam int OP_W       = 2;
   localparam int GROUP_W    = 5;
   localparam int INDEX_W    = 6;
   localparam int AGE_W      = 16;
   localparam int PROB_W     = 17;
   localparam int RAND_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int WIDTH_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_BANDS_DEFAULT  = 32;
   localparam int MAX_GROUPS_DEFAULT = 16;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(65536);
   localparam logic [4:0]        DIV_STEPS = 5'd17;

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
   localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RETRY     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_BAND   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_GROUP = 2'd3;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;
   localparam logic [1:0] KIND_FAIL   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BANDS_IN_USE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUPS_IN_USE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_WIDTH    = 2'd2;

   typedef struct packed {
      logic [INDEX_W-1:0] bands_in_use;
      logic [GROUP_W-1:0] groups_in_use;
      logic [WIDTH_W-1:0] band_width;
   } config_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [STATUS_W-1:0] fail_status;
      logic [GROUP_W-1:0]  group;
      logic [INDEX_W-1:0]  entry_index;
      logic [AGE_W-1:0]    entry_age;
      logic [PROB_W-1:0]   entry_prob;
      logic [RAND_W-1:0]   rand_band;
      logic [RAND_W-1:0]   rand_position;
      logic [AGE_W-1:0]    query_age;
   } entry_type;

endpackage

// File: design/picds_front.sv
// front end: takes request transfers, checks op, group and load index,
// saturates load probabilities; uses picds_pkg

module picds_front #(
   parameter int MAX_BANDS  = picds_pkg::MAX_BANDS_DEFAULT,
   parameter int MAX_GROUPS = picds_pkg::MAX_GROUPS_DEFAULT
) (
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [picds_pkg::OP_W-1:0]           req_op,
   input  logic [picds_pkg::GROUP_W-1:0]        req_group,
   input  logic [picds_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic [picds_pkg::AGE_W-1:0]          req_entry_age,
   input  logic [picds_pkg::PROB_W-1:0]         req_entry_prob,
   input  logic [picds_pkg::RAND_W-1:0]         req_rand_band,
   input  logic [picds_pkg::RAND_W-1:0]         req_rand_position,
   input  logic [picds_pkg::AGE_W-1:0]          req_query_age,
   input  picds_pkg::config_type                cfg,
   input  logic                                 queue_full,
   output logic                                 push,
   output picds_pkg::entry_type                 push_entry
);
   import picds_pkg::*;

   logic group_ok;
   logic index_ok;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   assign group_ok = (req_group != '0) && (req_group <= cfg.groups_in_use)
                     && (int'(req_group) <= MAX_GROUPS);
   assign index_ok = (req_entry_index != '0) && (int'(req_entry_index) <= MAX_BANDS);

   always_comb begin
      push_entry.fail_status   = STATUS_NO_BAND;
      push_entry.group         = req_group;
      push_entry.entry_index   = req_entry_index;
      push_entry.entry_age     = req_entry_age;
      push_entry.entry_prob    = (req_entry_prob > PROB_ONE) ? PROB_ONE : req_entry_prob;
      push_entry.rand_band     = req_rand_band;
      push_entry.rand_position = req_rand_position;
      push_entry.query_age     = req_query_age;
      push_entry.kind          = KIND_FAIL;
      unique case (req_op)
         OP_LOAD: begin
            if (!group_ok) begin
               push_entry.fail_status = STATUS_BAD_GROUP;
            end else if (index_ok) begin
               push_entry.kind = KIND_LOAD;
            end
         end
         OP_SAMPLE: begin
            if (!group_ok) begin
               push_entry.fail_status = STATUS_BAD_GROUP;
            end else begin
               push_entry.kind = KIND_SAMPLE;
            end
         end
         OP_QUERY: begin
            if (!group_ok) begin
               push_entry.fail_status = STATUS_BAD_GROUP;
            end else begin
               push_entry.kind = KIND_QUERY;
            end
         end
         OP_RSVD: begin
            push_entry.fail_status = STATUS_NO_BAND;
         end
         default: begin
            push_entry.kind = KIND_FAIL;
         end
      endcase
   end

endmodule

// File: design/picds_queue.sv
// short queue between front and back end of the sampler
// holds classified items; uses picds_pkg

module picds_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  picds_pkg::entry_type  push_entry,
   output logic                  full,
   output logic                  head_valid,
   output picds_pkg::entry_type  head,
   input  logic                  pop
);
   import picds_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
   localparam logic [PW:0]   CAP  = (PW + 1)'(QUEUE_DEPTH);

   entry_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     count_ff, count_in;

   assign full       = (count_ff == CAP);
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: design/picds_back.sv
// back end: band tables, band search, interpolation, band-width divider and
// result register; uses picds_pkg

module picds_back #(
   parameter int MAX_BANDS  = picds_pkg::MAX_BANDS_DEFAULT,
   parameter int MAX_GROUPS = picds_pkg::MAX_GROUPS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  picds_pkg::config_type             cfg,
   input  logic                              head_valid,
   input  picds_pkg::entry_type              head,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [picds_pkg::STATUS_W-1:0]    rsp_status,
   output logic [picds_pkg::AGE_W-1:0]       rsp_age_out,
   output logic [picds_pkg::INDEX_W-1:0]     rsp_band_index,
   output logic [picds_pkg::PROB_W-1:0]      rsp_band_prob
);
   import picds_pkg::*;

   localparam int DEPTH = MAX_BANDS * MAX_GROUPS;
   localparam int AW    = $clog2(DEPTH);
   localparam int OW    = $clog2(MAX_BANDS);
   localparam int BW    = $clog2(MAX_BANDS + 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SCAN   = 4'd1;
   localparam logic [3:0] ST_MUL    = 4'd2;
   localparam logic [3:0] ST_AGE    = 4'd3;
   localparam logic [3:0] ST_DIV    = 4'd4;
   localparam logic [3:0] ST_QRANGE = 4'd5;
   localparam logic [3:0] ST_QTOP   = 4'd6;
   localparam logic [3:0] ST_QBOT   = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   logic [AGE_W-1:0]  age_mem  [DEPTH];
   logic [PROB_W-1:0] prob_mem [DEPTH];
   logic [AGE_W-1:0]  age_rd_ff;
   logic [PROB_W-1:0] prob_rd_ff;

   logic [3:0]          state_ff, state_in;
   logic [AW-1:0]       base_ff, base_in;
   logic [BW-1:0]       band_ff, band_in;
   logic [PROB_W-1:0]   prev_cum_ff, prev_cum_in;
   logic [AGE_W-1:0]    prev_age_ff, prev_age_in;
   logic [AGE_W-1:0]    lo_ff, lo_in;
   logic [AGE_W-1:0]    hi_ff, hi_in;
   logic [RAND_W-1:0]   rand_band_ff, rand_band_in;
   logic [RAND_W-1:0]   rand_pos_ff, rand_pos_in;
   logic signed [32:0]  prod_ff, prod_in;
   logic [16:0]         num_ff, num_in;
   logic [16:0]         rem_ff, rem_in;
   logic [16:0]         quo_ff, quo_in;
   logic [4:0]          div_cnt_ff, div_cnt_in;
   logic [PROB_W-1:0]   top_ff, top_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [AGE_W-1:0]    res_age_ff, res_age_in;
   logic [INDEX_W-1:0]  res_band_ff, res_band_in;
   logic [PROB_W-1:0]   res_prob_ff, res_prob_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [AGE_W-1:0]    rsp_age_ff, rsp_age_in;
   logic [INDEX_W-1:0]  rsp_band_ff, rsp_band_in;
   logic [PROB_W-1:0]   rsp_prob_ff, rsp_prob_in;

   logic [BW-1:0]       n_bands;
   logic [WIDTH_W-1:0]  w_eff;
   logic [AW-1:0]       head_base;
   logic [AW-1:0]       rd_base;
   logic [OW-1:0]       rd_offset;
   logic [AW-1:0]       rd_addr;
   logic [AW-1:0]       wr_addr;
   logic                mem_we;
   logic [PROB_W-1:0]   cur_cum;
   logic                band_hit;
   logic signed [16:0]  diff;
   logic signed [16:0]  rpos_s;
   logic signed [33:0]  prod_full;
   logic signed [16:0]  shifted;
   logic signed [17:0]  hi_x;
   logic signed [17:0]  sh_x;
   logic signed [17:0]  age_x;
   logic [16:0]         rem_shift;
   logic [PROB_W-1:0]   bot_cum;

   always_comb begin
      if (cfg.bands_in_use == '0) begin
         n_bands = BW'(1);
      end else if (int'(cfg.bands_in_use) > MAX_BANDS) begin
         n_bands = BW'(MAX_BANDS);
      end else begin
         n_bands = BW'(cfg.bands_in_use);
      end
   end

   assign w_eff     = (cfg.band_width == '0) ? WIDTH_W'(1) : cfg.band_width;
   assign head_base = AW'((int'(head.group) - 1) * MAX_BANDS);
   assign wr_addr   = head_base + AW'(OW'(head.entry_index - INDEX_W'(1)));
   assign rd_addr   = rd_base + AW'(rd_offset);

   // band search compare
   assign cur_cum  = (band_ff >= n_bands) ? PROB_ONE : prob_rd_ff;
   assign band_hit = (prev_cum_ff < PROB_W'(rand_band_ff))
                     && (cur_cum >= PROB_W'(rand_band_ff));

   // interpolation arithmetic
   assign diff      = $signed({1'b0, hi_ff}) - $signed({1'b0, lo_ff});
   assign rpos_s    = $signed({1'b0, rand_pos_ff});
   assign prod_full = diff * rpos_s;
   assign shifted   = prod_ff[32:16];
   assign hi_x      = $signed({2'b00, hi_ff});
   assign sh_x      = $signed({shifted[16], shifted});
   assign age_x     = hi_x - sh_x;

   assign rem_shift = {rem_ff[15:0], num_ff[16]};
   assign bot_cum   = (band_ff == BW'(1)) ? '0 : prob_rd_ff;

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      band_in       = band_ff;
      prev_cum_in   = prev_cum_ff;
      prev_age_in   = prev_age_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rand_band_in  = rand_band_ff;
      rand_pos_in   = rand_pos_ff;
      prod_in       = prod_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      top_in        = top_ff;
      res_status_in = res_status_ff;
      res_age_in    = res_age_ff;
      res_band_in   = res_band_ff;
      res_prob_in   = res_prob_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_age_in    = rsp_age_ff;
      rsp_band_in   = rsp_band_ff;
      rsp_prob_in   = rsp_prob_ff;
      rd_base       = base_ff;
      rd_offset     = '0;
      mem_we        = 1'b0;
      pop           = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop          = 1'b1;
               base_in      = head_base;
               rd_base      = head_base;
               rand_band_in = head.rand_band;
               rand_pos_in  = head.rand_position;
               res_age_in   = '0;
               res_prob_in  = '0;
               res_band_in  = '0;
               case (head.kind)
                  KIND_LOAD: begin
                     mem_we        = 1'b1;
                     res_status_in = STATUS_OK;
                     res_band_in   = head.entry_index;
                     state_in      = ST_DONE;
                  end
                  KIND_SAMPLE: begin
                     band_in     = BW'(1);
                     prev_cum_in = '0;
                     prev_age_in = '0;
                     state_in    = ST_SCAN;
                  end
                  KIND_QUERY: begin
                     num_in     = 17'(head.query_age) + 17'(w_eff) - 17'd1;
                     rem_in     = '0;
                     quo_in     = '0;
                     div_cnt_in = DIV_STEPS;
                     state_in   = ST_DIV;
                  end
                  default: begin
                     res_status_in = head.fail_status;
                     state_in      = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // fetch next band while checking this one
            rd_offset = (int'(band_ff) >= MAX_BANDS) ? '0 : OW'(band_ff);
            if (band_hit) begin
               lo_in       = prev_age_ff;
               hi_in       = age_rd_ff;
               res_band_in = INDEX_W'(band_ff);
               state_in    = ST_MUL;
            end else if (band_ff == n_bands) begin
               res_status_in = STATUS_NO_BAND;
               state_in      = ST_DONE;
            end else begin
               prev_cum_in = cur_cum;
               prev_age_in = age_rd_ff;
               band_in     = band_ff + 1'b1;
            end
         end
         ST_MUL: begin
            prod_in  = prod_full[32:0];
            state_in = ST_AGE;
         end
         ST_AGE: begin
            if ((age_x == $signed({2'b00, lo_ff})) || (age_x == hi_x)) begin
               res_status_in = STATUS_RETRY;
            end else begin
               res_status_in = STATUS_OK;
               res_age_in    = age_x[AGE_W-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DIV: begin
            num_in = {num_ff[15:0], 1'b0};
            if (rem_shift >= 17'(w_eff)) begin
               rem_in = rem_shift - 17'(w_eff);
               quo_in = {quo_ff[15:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               quo_in = {quo_ff[15:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == 5'd1) begin
               state_in = ST_QRANGE;
            end
         end
         ST_QRANGE: begin
            if ((quo_ff != '0) && (quo_ff <= 17'(n_bands))) begin
               band_in   = BW'(quo_ff);
               rd_offset = OW'(quo_ff - 17'd1);
               state_in  = ST_QTOP;
            end else begin
               res_status_in = STATUS_NO_BAND;
               state_in      = ST_DONE;
            end
         end
         ST_QTOP: begin
            top_in    = (band_ff >= n_bands) ? PROB_ONE : prob_rd_ff;
            rd_offset = (band_ff >= BW'(2)) ? OW'(band_ff - BW'(2)) : '0;
            state_in  = ST_QBOT;
         end
         ST_QBOT: begin
            res_status_in = STATUS_OK;
            res_band_in   = INDEX_W'(band_ff);
            res_prob_in   = (top_ff >= bot_cum) ? top_ff - bot_cum : '0;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_age_in    = res_age_ff;
               rsp_band_in   = res_band_ff;
               rsp_prob_in   = res_prob_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      band_ff       <= band_in;
      prev_cum_ff   <= prev_cum_in;
      prev_age_ff   <= prev_age_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rand_band_ff  <= rand_band_in;
      rand_pos_ff   <= rand_pos_in;
      prod_ff       <= prod_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      div_cnt_ff    <= div_cnt_in;
      top_ff        <= top_in;
      res_status_ff <= res_status_in;
      res_age_ff    <= res_age_in;
      res_band_ff   <= res_band_in;
      res_prob_ff   <= res_prob_in;
      rsp_status_ff <= rsp_status_in;
      rsp_age_ff    <= rsp_age_in;
      rsp_band_ff   <= rsp_band_in;
      rsp_prob_ff   <= rsp_prob_in;
   end

   // band tables
   always_ff @(posedge clock) begin
      if (mem_we) begin
         age_mem[wr_addr]  <= head.entry_age;
         prob_mem[wr_addr] <= head.entry_prob;
      end
      age_rd_ff  <= age_mem[rd_addr];
      prob_rd_ff <= prob_mem[rd_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_age_out    = rsp_age_ff;
   assign rsp_band_index = rsp_band_ff;
   assign rsp_band_prob  = rsp_prob_ff;

`ifndef SYNTHESIS
   a_scan_band_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ((band_ff != '0) && (band_ff <= n_bands)))
      else $error("band search left the bands in use");

   a_query_band_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_QTOP) || (state_ff == ST_QBOT))
      |-> ((band_ff != '0) && (band_ff <= n_bands)))
      else $error("query band outside the bands in use");

   a_fail_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_OK))
      |-> ((rsp_age_ff == '0) && (rsp_prob_ff == '0)))
      else $error("failed result carries age or probability");

   a_retry_has_band: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_RETRY)) |-> (rsp_band_ff != '0))
      else $error("retry result without a band");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      (pop && (head.kind == KIND_SAMPLE)) |=> (state_ff == ST_SCAN))
      else $error("sample item did not start the band search");
`endif

endmodule

// File: design/piecewise_inverse_cdf_sampler.sv
// Piecewise inverse-cdf age sampler. Each group holds a table of band top
// ages (Q8.8) and cumulative probabilities (Q1.16). A load writes one band, a
// sample picks the band holding rand_band and interpolates an age inside it,
// a query returns the probability of the band holding query_age. The front
// end and a two-entry queue take new transfers while the back end works, so
// throughput is set by the back end: a load or a rejected item goes straight
// to the result register; a sample searches the bands in use, one band per
// cycle from the single-port band tables, until it finds one, then interpolates;
// a query runs a 17-step band-width divider, then two table reads, or stops
// after the divider when the age falls in no band.
// Band tables are not cleared at reset; read only bands that were loaded.
// Configuration is to be written only while idle; the block does not enforce it.

module piecewise_inverse_cdf_sampler #(
   parameter int MAX_BANDS  = picds_pkg::MAX_BANDS_DEFAULT,
   parameter int MAX_GROUPS = picds_pkg::MAX_GROUPS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [picds_pkg::OP_W-1:0]           req_op,
   input  logic [picds_pkg::GROUP_W-1:0]        req_group,
   input  logic [picds_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic [picds_pkg::AGE_W-1:0]          req_entry_age,
   input  logic [picds_pkg::PROB_W-1:0]         req_entry_prob,
   input  logic [picds_pkg::RAND_W-1:0]         req_rand_band,
   input  logic [picds_pkg::RAND_W-1:0]         req_rand_position,
   input  logic [picds_pkg::AGE_W-1:0]          req_query_age,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [picds_pkg::STATUS_W-1:0]       rsp_status,
   output logic [picds_pkg::AGE_W-1:0]          rsp_age_out,
   output logic [picds_pkg::INDEX_W-1:0]        rsp_band_index,
   output logic [picds_pkg::PROB_W-1:0]         rsp_band_prob,
   input  logic                                 csr_write_enable,
   input  logic [picds_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [picds_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import picds_pkg::*;

   config_type cfg_ff, cfg_in;
   logic       queue_full;
   logic       push;
   entry_type  push_entry;
   logic       head_valid;
   entry_type  head;
   logic       pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BANDS_IN_USE:  cfg_in.bands_in_use  = csr_write_data[INDEX_W-1:0];
            CSR_GROUPS_IN_USE: cfg_in.groups_in_use = csr_write_data[GROUP_W-1:0];
            CSR_BAND_WIDTH:    cfg_in.band_width    = csr_write_data[WIDTH_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bands_in_use  <= INDEX_W'(32);
         cfg_ff.groups_in_use <= GROUP_W'(16);
         cfg_ff.band_width    <= WIDTH_W'(1280);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   picds_front #(
      .MAX_BANDS  (MAX_BANDS),
      .MAX_GROUPS (MAX_GROUPS)
   ) u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_group         (req_group),
      .req_entry_index   (req_entry_index),
      .req_entry_age     (req_entry_age),
      .req_entry_prob    (req_entry_prob),
      .req_rand_band     (req_rand_band),
      .req_rand_position (req_rand_position),
      .req_query_age     (req_query_age),
      .cfg               (cfg_ff),
      .queue_full        (queue_full),
      .push              (push),
      .push_entry        (push_entry)
   );

   picds_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   picds_back #(
      .MAX_BANDS  (MAX_BANDS),
      .MAX_GROUPS (MAX_GROUPS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head_valid     (head_valid),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_age_out    (rsp_age_out),
      .rsp_band_index (rsp_band_index),
      .rsp_band_prob  (rsp_band_prob)
   );

endmodule
